### rtl/rks_pkg.sv
// Package for the running K-th smallest selector: widths, register map,
// and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rks_pkg;

  // Field widths fixed by the interface.
  localparam int DATA_W = 32;
  localparam int POS_W  = 32;
  localparam int RANK_W = 7;

  // Default depth of the sorted store.
  localparam int MAX_K_DEF = 64;

  // Configuration port.
  localparam int          CFG_DATA_W = 32;
  localparam int          CFG_ADDR_W = 3;
  localparam logic        REG_RANK_K = 1'b0;  // register index, taken from paddr[2]
  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // load a new item, restart and counter handling
    logic rd_walk;   // read the entry just below the current hole
    logic shift_wr;  // move the read entry up into the hole
    logic place_wr;  // write the new item into the hole
    logic rd_out;    // read the entry at the effective rank
    logic load_out;  // copy the read entry into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hole_at_zero;  // the hole has reached the bottom of the store
    logic new_before;    // the new item sorts strictly before the read entry
    logic have_result;   // the store holds at least K entries
    logic out_busy;      // a result waits and is stalled
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/running_kth_smallest_top.sv
// Top level of the running K-th smallest selector: configuration register
// and the controller and datapath. Uses rks_pkg, rks_ctrl and rks_datapath.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall   in_restart, in_sample_value
//   out_      output     out_valid / out_stall out_kth_position, out_kth_value
//   cfg_      input      APB psel/penable      rank_k at byte address 0
//
// An item is taken only while the controller is idle. Its insertion walk reads
// the single store RAM one entry at a time and moves up each kept entry that
// sorts after it; a result is read out only when the store holds K entries or
// more, and is loaded only while the output register is free. Reset is
// synchronous and active low; the store needs no clearing. A stalled result
// waits in the output register while the next item is inserted.
`timescale 1ns / 1ps
`default_nettype none

module running_kth_smallest_top
  import rks_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_restart,
  input  wire logic [DATA_W-1:0]     in_sample_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [POS_W-1:0]      out_kth_position,
  output logic      [DATA_W-1:0]     out_kth_value,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [RANK_W-1:0] rank_k_r;
  logic              cfg_wr;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_RANK_K);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_k_r <= RANK_RESET;
    end else if (cfg_wr) begin
      rank_k_r <= cfg_pwdata[RANK_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_RANK_K) ?
                      {{(CFG_DATA_W-RANK_W){1'b0}}, rank_k_r} : '0;

  rks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rks_datapath #(
    .MAX_K (MAX_K)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_restart       (in_restart),
    .in_sample_value  (in_sample_value),
    .rank_k           (rank_k_r),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_kth_position (out_kth_position),
    .out_kth_value    (out_kth_value)
  );

endmodule

`default_nettype wire

### rtl/rks_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rks_ram #(
  parameter int W  = 64,
  parameter int D  = 64,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/rks_datapath.sv
// Datapath of the K-th smallest selector: item registers, counters, the
// sorted store in RAM, and the output register. Uses rks_pkg and rks_ram.
`timescale 1ns / 1ps
`default_nettype none

module rks_datapath
  import rks_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctrl_cmd_t         cmd,
  output dp_stat_t               stat,
  input  wire logic              in_restart,
  input  wire logic [DATA_W-1:0] in_sample_value,
  input  wire logic [RANK_W-1:0] rank_k,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic      [POS_W-1:0]  out_kth_position,
  output logic      [DATA_W-1:0] out_kth_value
);

  // CW holds an entry count 0..MAX_K, AW an entry index.
  localparam int CW = $clog2(MAX_K + 1);
  localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int RW = (CW > RANK_W) ? CW : RANK_W;
  localparam int EW = POS_W + DATA_W;

  logic [DATA_W-1:0] val_r;
  logic [POS_W-1:0]  pos_r;
  logic [CW-1:0]     hole_r;
  logic [CW-1:0]     count_r;
  logic [POS_W-1:0]  arr_r;
  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [DATA_W-1:0] out_val_r;

  logic [CW-1:0]     start;
  logic [POS_W-1:0]  arr_base;
  logic [POS_W-1:0]  arr_nxt;
  logic [CW-1:0]     count_nxt;
  logic [CW-1:0]     hole_m1;
  logic [RW-1:0]     rank_ext;
  logic [CW-1:0]     eff_rank;
  logic [CW-1:0]     eff_m1;
  logic              hole_full;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_wdata;
  logic [EW-1:0]     ram_rdata;
  logic [POS_W-1:0]  rd_pos;
  logic [DATA_W-1:0] rd_val;

  // Restart empties the store and counter; the counter saturates at its top.
  always_comb begin
    start     = in_restart ? '0 : count_r;
    arr_base  = in_restart ? '0 : arr_r;
    arr_nxt   = (arr_base == '1) ? arr_base : arr_base + 1'b1;
    count_nxt = (start == CW'(MAX_K)) ? start : start + 1'b1;
  end

  // Rank zero counts as one; ranks above the store depth clamp to it.
  always_comb begin
    rank_ext = RW'(rank_k);
    if (rank_k == '0) begin
      eff_rank = CW'(1);
    end else if (rank_ext > RW'(MAX_K)) begin
      eff_rank = CW'(MAX_K);
    end else begin
      eff_rank = rank_ext[CW-1:0];
    end
    eff_m1 = eff_rank - 1'b1;
  end

  assign hole_m1   = hole_r - 1'b1;
  assign hole_full = (hole_r == CW'(MAX_K));

  // Item, counter and walk registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      arr_r   <= '0;
    end else if (cmd.accept) begin
      count_r <= count_nxt;
      arr_r   <= arr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r  <= in_sample_value;
      pos_r  <= arr_nxt;
      hole_r <= start;
    end else if (cmd.shift_wr) begin
      hole_r <= hole_m1;
    end
  end

  // The store walks a hole down from its end; a hole past the last slot drops its write.
  assign ram_we    = (cmd.shift_wr || cmd.place_wr) && !hole_full;
  assign ram_wdata = cmd.shift_wr ? ram_rdata : {pos_r, val_r};
  assign ram_re    = cmd.rd_walk || cmd.rd_out;
  assign ram_raddr = cmd.rd_out ? eff_m1[AW-1:0] : hole_m1[AW-1:0];

  rks_ram #(
    .W (EW),
    .D (MAX_K)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hole_r[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_pos = ram_rdata[EW-1:DATA_W];
  assign rd_val = ram_rdata[DATA_W-1:0];

  // Ordering by value, then by arrival; equal pairs keep the stored entry first.
  always_comb begin
    stat.hole_at_zero = (hole_r == '0);
    stat.new_before   = (val_r < rd_val) || ((val_r == rd_val) && (pos_r < rd_pos));
    stat.have_result  = (count_r >= eff_rank);
    stat.out_busy     = out_valid_r && out_stall;
  end

  // Output register lets a waiting result sit while the next item is worked on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pos_r <= rd_pos;
      out_val_r <= rd_val;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kth_position = out_pos_r;
  assign out_kth_value    = out_val_r;

endmodule

`default_nettype wire

### rtl/rks_ctrl.sv
// Controller of the K-th smallest selector: sequences one item through the
// insertion walk and the result read. Uses rks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rks_ctrl
  import rks_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_ORD   = 6'b001000,
    S_OWAIT = 6'b010000,
    S_OLOAD = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        if (stat.hole_at_zero) begin
          cmd.place_wr = 1'b1;
          state_nxt    = S_ORD;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.new_before) begin
          cmd.shift_wr = 1'b1;
          state_nxt    = S_RD;
        end else begin
          cmd.place_wr = 1'b1;
          state_nxt    = S_ORD;
        end
      end
      S_ORD: begin
        if (stat.have_result) begin
          cmd.rd_out = 1'b1;
          state_nxt  = S_OWAIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OWAIT: begin
        state_nxt = S_OLOAD;
      end
      S_OLOAD: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // One item at a time: the input is open only while idle.
  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

### rtl/rks_checker.sv
// Port-level checks for the running K-th smallest selector, bound to the top
// level. Uses rks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rks_checker
  import rks_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  in_restart,
  input wire logic [DATA_W-1:0]     in_sample_value,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [POS_W-1:0]      out_kth_position,
  input wire logic [DATA_W-1:0]     out_kth_value,
  input wire logic                  cfg_psel,
  input wire logic                  cfg_penable,
  input wire logic                  cfg_pwrite,
  input wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  input wire logic [CFG_DATA_W-1:0] cfg_prdata,
  input wire logic                  cfg_pready
);

  // A stalled result stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kth_position)
                               && $stable(out_kth_value))
    else $error("stalled result changed");

  // Items are worked one at a time: an accepted item closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accepted item");

  // Arrival positions start at one, so a result never shows position zero.
  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kth_position != '0)
    else $error("result with position zero");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind running_kth_smallest_top rks_checker u_rks_checker (.*);

`default_nettype wire

### bench/tb.sv
// Testbench for running_kth_smallest_top: drives random and directed items,
// predicts each K-th smallest result and compares it at the output channel.
// Depends on rks_pkg and the RTL of running_kth_smallest_top.
`timescale 1ns / 1ps

module tb;
  import rks_pkg::*;

  localparam int MAX_K         = MAX_K_DEF;
  // The slowest item moves every kept entry once, then allow a margin.
  localparam int SETTLE_CYCLES = 2 * MAX_K + 25;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int IDLE_PCT      = 19;
  localparam int LONG_HOLD     = 600;
  localparam logic [CFG_ADDR_W-1:0] RANK_ADDR = CFG_ADDR_W'({REG_RANK_K, 2'b00});

  // Shapes of the value stream; runs of one shape give ties and ordered inputs.
  typedef enum int unsigned {
    STYLE_WIDE,
    STYLE_NARROW,
    STYLE_EDGES,
    STYLE_RISING,
    STYLE_FALLING,
    STYLE_TOP
  } sample_style_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } kth_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_restart = 1'b0;
  logic [DATA_W-1:0]     in_sample_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [POS_W-1:0]      out_kth_position;
  logic [DATA_W-1:0]     out_kth_value;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Shared run state.
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  int          failures = 0;
  int          samples_taken = 0;
  int          results_checked = 0;
  int          rank_writes = 0;
  int unsigned cycle_count = 0;

  // Predictor state: sorted store, arrival counter and rank register.
  logic [DATA_W-1:0] sorted_val[MAX_K];
  logic [POS_W-1:0]  sorted_pos[MAX_K];
  int                sorted_count = 0;
  logic [POS_W-1:0]  arrival_pos = '0;
  logic [RANK_W-1:0] rank_reg = RANK_RESET;
  kth_result_t       kth_expected[$];

  running_kth_smallest_top #(.MAX_K(MAX_K)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_restart       (in_restart),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kth_position (out_kth_position),
    .out_kth_value    (out_kth_value),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #5 clk = ~clk;

  // Equal values are ordered by arrival, so the earlier one sorts first.
  function automatic bit entry_precedes(input logic [DATA_W-1:0] va, input logic [POS_W-1:0] pa,
                                        input logic [DATA_W-1:0] vb, input logic [POS_W-1:0] pb);
    if (va != vb) return va < vb;
    return pa < pb;
  endfunction

  // Insert one accepted item into the predicted store and queue its result if one is due.
  function void rank_sample(input logic restart, input logic [DATA_W-1:0] draw);
    int slot;
    int last;
    int eff;
    if (restart) begin
      sorted_count = 0;
      arrival_pos = '0;
    end
    if (arrival_pos != '1) arrival_pos++;
    slot = 0;
    while (slot < sorted_count &&
           !entry_precedes(draw, arrival_pos, sorted_val[slot], sorted_pos[slot]))
      slot++;
    // An entry that sorts after a full store is dropped.
    if (slot < MAX_K) begin
      last = (sorted_count < MAX_K) ? sorted_count : MAX_K - 1;
      for (int j = last; j > slot; j--) begin
        sorted_val[j] = sorted_val[j-1];
        sorted_pos[j] = sorted_pos[j-1];
      end
      sorted_val[slot] = draw;
      sorted_pos[slot] = arrival_pos;
      if (sorted_count < MAX_K) sorted_count++;
    end
    // A rank of zero counts as one, and ranks past the store depth are clamped.
    eff = (rank_reg == 0) ? 1 : ((int'(rank_reg) > MAX_K) ? MAX_K : int'(rank_reg));
    if (sorted_count >= eff)
      kth_expected.insert(kth_expected.size(),
                          kth_result_t'{position: sorted_pos[eff-1],
                                        value: sorted_val[eff-1]});
  endfunction

  function automatic logic [DATA_W-1:0] draw_sample(input sample_style_t style,
                                                    input int unsigned seq);
    case (style)
      STYLE_WIDE:    return $urandom;
      STYLE_NARROW:  return DATA_W'($urandom_range(15));
      STYLE_EDGES:   return $urandom_range(1) ? '1 : '0;
      STYLE_RISING:  return DATA_W'(seq) * 32'd977;
      STYLE_FALLING: return ~(DATA_W'(seq) * 32'd977);
      default:       return 32'hFFFF_FFF0 | DATA_W'($urandom_range(15));
    endcase
  endfunction

  // Predict every item as the block accepts it.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      rank_sample(in_restart, in_sample_value);
      samples_taken++;
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    kth_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (kth_expected.size() == 0) begin
        $error("result with none expected: kth_position %0d, kth_value 0x%08h",
               out_kth_position, out_kth_value);
        failures++;
      end else begin
        want = kth_expected.pop_front();
        results_checked++;
        if (out_kth_position !== want.position) begin
          $error("kth_position: expected %0d, actual %0d", want.position, out_kth_position);
          failures++;
        end
        if (out_kth_value !== want.value) begin
          $error("kth_value: expected 0x%08h, actual 0x%08h", want.value, out_kth_value);
          failures++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("no progress within %0d cycles", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one item, with random gaps first; returns at a falling edge.
  task automatic send_sample(input logic restart, input logic [DATA_W-1:0] draw);
    while (!calm && $urandom_range(99) < IDLE_PCT) @(negedge clk);
    in_valid = 1'b1;
    in_restart = restart;
    in_sample_value = draw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Read the rank register back and compare it with the predicted value.
  task automatic read_rank();
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b0;
    cfg_paddr = RANK_ADDR;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[RANK_W-1:0] !== rank_reg) begin
      $error("rank_k: expected %0d, actual %0d", rank_reg, cfg_prdata[RANK_W-1:0]);
      failures++;
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Write the rank register, then read it back.
  task automatic set_rank(input logic [RANK_W-1:0] rank);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = RANK_ADDR;
    cfg_pwdata = CFG_DATA_W'(rank);
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rank_reg = rank;
    rank_writes++;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    read_rank();
  endtask

  // Wait for every predicted result, then for the longest insertion to finish.
  task automatic settle();
    while (kth_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_calm(input bit on);
    @(posedge clk);
    calm = on;
    @(negedge clk);
  endtask

  // Extreme values, ties, and every kind of rank setting.
  task automatic test_directed();
    read_rank();
    send_sample(1'b1, '1);
    send_sample(1'b0, '0);
    send_sample(1'b0, '1);
    send_sample(1'b0, '0);
    send_sample(1'b0, 32'h8000_0000);
    settle();
    // Rank zero behaves like rank one.
    set_rank('0);
    send_sample(1'b0, 32'h1234_5678);
    send_sample(1'b0, 32'h0000_0001);
    settle();
    // Three equal values rank by arrival.
    set_rank(RANK_W'(3));
    send_sample(1'b1, 32'd7);
    send_sample(1'b0, 32'd7);
    send_sample(1'b0, 32'd7);
    send_sample(1'b0, 32'd6);
    send_sample(1'b0, 32'hAAAA_AAAA);
    send_sample(1'b0, 32'h5555_5555);
    settle();
    // Ranks above the store depth clamp to it, so nothing comes out yet.
    set_rank('1);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'd3);
    settle();
    set_rank(RANK_W'(MAX_K + 1));
    send_sample(1'b0, 32'd9);
    settle();
    set_rank(RANK_W'(MAX_K));
    send_sample(1'b0, '1);
    settle();
  endtask

  // Random streams under a series of ranks, changed mid-stream without restart.
  task automatic test_random_ranks();
    logic [RANK_W-1:0] rank_plan[10];
    sample_style_t     style;
    int unsigned       seq;
    int                count;
    int                restart_pct;
    logic              restart;
    rank_plan = '{RANK_W'(MAX_K), RANK_W'(1), RANK_W'(0), RANK_W'(2), '1, RANK_W'(5),
                  RANK_W'(MAX_K + 1), RANK_W'(17), RANK_W'(40),
                  RANK_W'($urandom_range(1, MAX_K))};
    seq = 0;
    style = STYLE_RISING;
    foreach (rank_plan[p]) begin
      set_rank(rank_plan[p]);
      if (p == 1) set_calm(1'b1);
      if (p == 3) set_calm(1'b0);
      // High ranks need a long run without restarts before any result appears.
      restart_pct = (rank_plan[p] == 0 || rank_plan[p] > 16) ? 0 : 3;
      // The first phase fills the store, then offers items that sort after every kept entry and are dropped.
      count = (p == 0) ? 130 : 85;
      for (int i = 0; i < count; i++) begin
        if (p == 0)
          style = (i < 70) ? STYLE_RISING : ((i < 100) ? STYLE_FALLING : STYLE_WIDE);
        else if ($urandom_range(19) == 0)
          style = sample_style_t'($urandom_range(STYLE_TOP));
        restart = (i == 0 && p != 0 && $urandom_range(1)) ||
                  ($urandom_range(99) < restart_pct);
        send_sample(restart, draw_sample(style, seq));
        seq++;
      end
      settle();
    end
  endtask

  // The receiver holds off for a long time while the sender keeps offering items.
  task automatic test_backpressure();
    set_rank(RANK_W'(2));
    set_calm(1'b1);
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    for (int i = 0; i < 40; i++)
      send_sample(i == 0, draw_sample(STYLE_WIDE, 0));
    set_calm(1'b0);
    settle();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_ranks();
    test_backpressure();
    settle();
    $display("Sent %0d items under %0d rank writes and compared %0d K-th smallest results.",
             samples_taken, rank_writes, results_checked);
    $display("Run covered ties, extreme values, clamped ranks, a full store and a long stall.");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/rks_pkg.sv
rtl/rks_ram.sv
rtl/rks_datapath.sv
rtl/rks_ctrl.sv
rtl/running_kth_smallest_top.sv
rtl/rks_checker.sv
bench/tb.sv
